// ===== src/lsbpe_pkg.sv =====
// Shared types and constants for the LSB parity stego embed/extract block.
package lsbpe_pkg;

  localparam int LENGTH_BITS_DEF = 16;
  localparam int CFG_INDEX_W     = 4;
  localparam int CFG_DATA_W      = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_MODE          = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_SECRET_LENGTH = CFG_INDEX_W'(1);

  localparam logic MODE_EMBED   = 1'b0;
  localparam logic MODE_EXTRACT = 1'b1;

  localparam logic [7:0] PARITY_PIVOT = 8'd127;

  typedef struct packed {
    logic [7:0] carrier_byte;
    logic       effective;
    logic [7:0] secret_byte;
    logic       message_start;
  } item_t;

  typedef struct packed {
    logic [7:0] carrier_out;
    logic [7:0] secret_out;
    logic       secret_out_valid;
    logic       finished;
  } result_t;

  typedef struct packed {
    logic        mode;
    logic [15:0] secret_length;
  } cfg_t;

endpackage

// ===== src/lsbpe_cfg.sv =====
// Configuration register file: mode and secret length.
module lsbpe_cfg
  import lsbpe_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                   cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode          <= MODE_EMBED;
      cfg.secret_length <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MODE:          cfg.mode          <= cfg_data[0];
        CFG_SECRET_LENGTH: cfg.secret_length <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== src/lsbpe_core.sv =====
// Message state and per-word embed/extract logic.
module lsbpe_core
  import lsbpe_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  item_t   item,
  input  logic    step,
  output result_t result
);

  localparam int CW = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;

  logic [2:0]             bit_position, bit_position_next;
  logic [LENGTH_BITS-1:0] bytes_done, bytes_done_next;
  logic [7:0]             gathered_byte, gathered_byte_next;
  logic [7:0]             held_secret, held_secret_next;

  logic [CW-1:0]          len_wide;
  logic [LENGTH_BITS-1:0] len;
  logic [2:0]             bp, shift;
  logic [LENGTH_BITS-1:0] bd;
  logic [7:0]             gb, hs, cout;
  logic                   active, want_odd;

  assign len_wide = CW'(cfg.secret_length);
  assign len      = LENGTH_BITS'(len_wide);

  always_comb begin
    bp    = item.message_start ? 3'd0 : bit_position;
    bd    = item.message_start ? '0   : bytes_done;
    gb    = item.message_start ? 8'd0 : gathered_byte;
    hs    = item.message_start ? 8'd0 : held_secret;
    shift = ~bp;  // 7 - bit position, MSB first
    active = item.effective && (bd < len);
    cout   = item.carrier_byte;
    want_odd = 1'b0;

    bit_position_next  = bp;
    bytes_done_next    = bd;
    gathered_byte_next = gb;
    held_secret_next   = hs;
    result.secret_out       = 8'd0;
    result.secret_out_valid = 1'b0;

    if (active) begin
      if (cfg.mode == MODE_EMBED) begin
        if (bp == 3'd0) held_secret_next = item.secret_byte;
        want_odd = held_secret_next[shift];
        if (item.carrier_byte[0] != want_odd) begin
          cout = (item.carrier_byte < PARITY_PIVOT) ? item.carrier_byte + 8'd1
                                                    : item.carrier_byte - 8'd1;
        end
      end else begin
        gathered_byte_next[shift] = gb[shift] | item.carrier_byte[0];
      end
      bit_position_next = bp + 3'd1;
      if (bp == 3'd7) begin
        bytes_done_next = bd + LENGTH_BITS'(1);
        if (cfg.mode == MODE_EXTRACT) begin
          result.secret_out       = gathered_byte_next;
          result.secret_out_valid = 1'b1;
          gathered_byte_next      = 8'd0;
        end
      end
    end

    result.carrier_out = cout;
    result.finished    = (bytes_done_next >= len);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_position  <= '0;
      bytes_done    <= '0;
      gathered_byte <= '0;
      held_secret   <= '0;
    end else if (step) begin
      bit_position  <= bit_position_next;
      bytes_done    <= bytes_done_next;
      gathered_byte <= gathered_byte_next;
      held_secret   <= held_secret_next;
    end
  end

endmodule

// ===== src/lsb_parity_stego_embed_extract.sv =====
// Top level: input register, embed/extract logic, result register.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+---------------------------
//  item     | item_valid / item_ready   | item (item_t)
//  result   | result_valid/result_ready | result (result_t)
//  cfg      | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// One word per cycle unless the result stalls; input register, then result
// register. Message state advances as a word moves into the result register.
// rst is synchronous and clears cfg, state and both valids, not the payloads.
// A stalled result holds the pipe; the input register still takes one word.
module lsb_parity_stego_embed_extract
  import lsbpe_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  item_t                  item,
  output logic                   result_valid,
  input  logic                   result_ready,
  output result_t                result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t    cfg;
  item_t   held_item;
  logic    held_valid;
  logic    step;
  result_t result_next;

  lsbpe_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lsbpe_core #(.LENGTH_BITS(LENGTH_BITS)) u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .item   (held_item),
    .step   (step),
    .result (result_next)
  );

  assign step       = held_valid && (!result_valid || result_ready);
  assign item_ready = !held_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (item_ready) begin
      held_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) held_item <= item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (!result_valid || result_ready) begin
      result_valid <= held_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) result <= result_next;
  end

endmodule

// ===== src/lsbpe_checker.sv =====
// Port-level checks for the stego block, bound to the top level.
module lsbpe_checker
  import lsbpe_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   item_ready,
  input logic                   result_valid,
  input logic                   result_ready,
  input result_t                result
);

  // stalled result word holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result word changed while stalled");

  // input side only backs up behind a stalled result
  a_ready_backpressure: assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> result_valid && !result_ready)
    else $error("item_ready low without result stall");

  a_no_secret_when_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.secret_out_valid |-> result.secret_out == 8'd0)
    else $error("secret_out nonzero without secret_out_valid");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

endmodule

bind lsb_parity_stego_embed_extract lsbpe_checker u_lsbpe_checker (.*);
